// ===== rtl/core/tce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants of the text terminal cursor engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  typedef enum logic [2:0] {
    CMD_PRINT      = 3'd0,
    CMD_SET_CURSOR = 3'd1,
    CMD_WRITE_AT   = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_READ_CELL  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    OP_PLAIN,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_TAB,
    OP_SET_CURSOR,
    OP_WRITE_AT,
    OP_CLEAR,
    OP_READ_CELL,
    OP_NONE
  } op_e;

  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_RETURN    = 8'h0D;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

  // classified item passed from the front end to the back end
  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/core/tce_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tce_front
// Accepts commands, decodes them and clamps or range-checks positions.
// ----------------------------------------------------------------------------
module tce_front import tce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [2:0]        command_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic signed [7:0] pos_x_i,
  input  wire logic signed [7:0] pos_y_i,
  input  wire logic              q_full_i,
  input  wire logic              init_i,
  output      logic              push_o,
  output      op_t               item_o
);

  localparam logic [7:0] COLS_L   = 8'(COLUMNS);
  localparam logic [7:0] ROWS_L   = 8'(ROWS);
  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

  logic x_neg, y_neg, x_high, y_high, on_screen;

  assign busy   = q_full_i | init_i;
  assign push_o = start & ~busy;

  assign x_neg     = pos_x_i[7];
  assign y_neg     = pos_y_i[7];
  assign x_high    = {1'b0, pos_x_i[6:0]} >= COLS_L;
  assign y_high    = {1'b0, pos_y_i[6:0]} >= ROWS_L;
  assign on_screen = ~x_neg & ~y_neg & ~x_high & ~y_high;

  always_comb begin
    item_o.op        = OP_NONE;
    item_o.char_code = char_code_i;
    item_o.col       = pos_x_i[6:0];
    item_o.row       = pos_y_i[4:0];
    case (command_i)
      CMD_PRINT: begin
        case (char_code_i)
          CH_NEWLINE:   item_o.op = OP_NEWLINE;
          CH_RETURN:    item_o.op = OP_RETURN;
          CH_BACKSPACE: item_o.op = OP_BACKSPACE;
          CH_TAB:       item_o.op = OP_TAB;
          default:      item_o.op = OP_PLAIN;
        endcase
      end
      CMD_SET_CURSOR: begin
        item_o.op  = OP_SET_CURSOR;
        item_o.col = x_neg ? 7'd0 : (x_high ? COL_LAST : pos_x_i[6:0]);
        item_o.row = y_neg ? 5'd0 : (y_high ? ROW_LAST : pos_y_i[4:0]);
      end
      CMD_WRITE_AT:  item_o.op = on_screen ? OP_WRITE_AT : OP_NONE;
      CMD_CLEAR:     item_o.op = OP_CLEAR;
      CMD_READ_CELL: item_o.op = on_screen ? OP_READ_CELL : OP_NONE;
      default:       item_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/tce_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tce_queue
// Two-entry queue of decoded items between front and back end.
// ----------------------------------------------------------------------------
module tce_queue import tce_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  item_i,
  input  wire logic pop_i,
  output      logic valid_o,
  output      op_t  item_o,
  output      logic full_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tce_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tce_back
// Executes decoded items on the cursor and the screen store: printing,
// tab expansion, scroll, clear and cell reads, plus the clearing pass.
// ----------------------------------------------------------------------------
module tce_back import tce_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  attr_i,
  input  wire logic        q_valid_i,
  input  wire op_t         q_item_i,
  output      logic        pop_o,
  output      logic        init_o,
  output      logic        done_o,
  output      logic [6:0]  cursor_column_o,
  output      logic [4:0]  cursor_row_o,
  output      logic [10:0] cursor_linear_o,
  output      logic [7:0]  cell_character_o,
  output      logic [7:0]  cell_attribute_o,
  output      logic        cell_valid_o
);

  localparam int         COL_W    = $clog2(COLUMNS);
  localparam int         ROW_W    = $clog2(ROWS);
  localparam int         AW       = COL_W + ROW_W;
  localparam int         DEPTH    = 2 ** AW;
  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
  localparam logic [10:0] COLS_11 = 11'(COLUMNS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_BLANK,
    S_CLEAR,
    S_TAB
  } state_e;

  // spaces to the next tab stop, one entry per column
  typedef logic [127:0][4:0] gap_table_t;

  function automatic gap_table_t tab_gaps();
    gap_table_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 5'(TAB_STOP - (i % TAB_STOP));
    end
    return t;
  endfunction

  localparam gap_table_t TAB_GAPS = tab_gaps();

  function automatic logic [AW-1:0] cell_addr(input logic [4:0] r, input logic [6:0] c);
    cell_addr = {r[ROW_W-1:0], c[COL_W-1:0]};
  endfunction

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata_q;

  state_e        state_q, state_d;
  logic [6:0]    col_q, col_d;
  logic [4:0]    row_q, row_d;
  logic [6:0]    sw_col_q, sw_col_d;
  logic [4:0]    sw_row_q, sw_row_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [4:0]    tab_left_q, tab_left_d;
  logic          in_tab_q, in_tab_d;
  logic          done_q, done_d;
  logic [7:0]    cchar_q, cchar_d;
  logic [7:0]    cattr_q, cattr_d;
  logic          cvalid_q, cvalid_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, blank;
  logic          last_col, last_row, sw_last_col, sw_last_row, last_space;

  assign blank       = {attr_i, CH_SPACE};
  assign last_col    = col_q == COL_LAST;
  assign last_row    = row_q == ROW_LAST;
  assign sw_last_col = sw_col_q == COL_LAST;
  assign sw_last_row = sw_row_q == ROW_LAST;
  assign last_space  = tab_left_q == 5'd1;

  assign init_o           = state_q == S_INIT;
  assign done_o           = done_q;
  assign cursor_column_o  = col_q;
  assign cursor_row_o     = row_q;
  assign cursor_linear_o  = 11'({6'd0, row_q} * COLS_11) + {4'd0, col_q};
  assign cell_character_o = cchar_q;
  assign cell_attribute_o = cattr_q;
  assign cell_valid_o     = cvalid_q;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    sw_col_d   = sw_col_q;
    sw_row_d   = sw_row_q;
    pend_d     = pend_q;
    wa_d       = wa_q;
    tab_left_d = tab_left_q;
    in_tab_d   = in_tab_q;
    done_d     = 1'b0;
    cchar_d    = 8'd0;
    cattr_d    = 8'd0;
    cvalid_d   = 1'b0;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = cell_addr(row_q, col_q);
    wdata      = blank;
    raddr      = cell_addr(row_q, col_q);
    case (state_q)
      S_INIT, S_CLEAR: begin
        we       = 1'b1;
        waddr    = cell_addr(sw_row_q, sw_col_q);
        wdata    = (state_q == S_INIT) ? RESET_CELL : blank;
        sw_col_d = sw_col_q + 7'd1;
        if (sw_last_col) begin
          sw_col_d = 7'd0;
          sw_row_d = sw_row_q + 5'd1;
          if (sw_last_row) begin
            sw_row_d = 5'd0;
            state_d  = S_IDLE;
            done_d   = state_q == S_CLEAR;
          end
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          case (q_item_i.op)
            OP_PLAIN: begin
              we       = 1'b1;
              wdata    = {attr_i, q_item_i.char_code};
              in_tab_d = 1'b0;
              if (last_col) begin
                col_d = 7'd0;
                if (last_row) begin
                  sw_row_d = 5'd1;
                  sw_col_d = 7'd0;
                  pend_d   = 1'b0;
                  state_d  = S_SCROLL;
                end else begin
                  row_d  = row_q + 5'd1;
                  done_d = 1'b1;
                end
              end else begin
                col_d  = col_q + 7'd1;
                done_d = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_d    = 7'd0;
              in_tab_d = 1'b0;
              if (last_row) begin
                sw_row_d = 5'd1;
                sw_col_d = 7'd0;
                pend_d   = 1'b0;
                state_d  = S_SCROLL;
              end else begin
                row_d  = row_q + 5'd1;
                done_d = 1'b1;
              end
            end
            OP_RETURN: begin
              col_d  = 7'd0;
              done_d = 1'b1;
            end
            OP_BACKSPACE: begin
              if (col_q != 7'd0) begin
                col_d = col_q - 7'd1;
                we    = 1'b1;
                waddr = cell_addr(row_q, col_q - 7'd1);
              end
              done_d = 1'b1;
            end
            OP_TAB: begin
              tab_left_d = TAB_GAPS[col_q];
              state_d    = S_TAB;
            end
            OP_SET_CURSOR: begin
              col_d  = q_item_i.col;
              row_d  = q_item_i.row;
              done_d = 1'b1;
            end
            OP_WRITE_AT: begin
              we     = 1'b1;
              waddr  = cell_addr(q_item_i.row, q_item_i.col);
              wdata  = {attr_i, q_item_i.char_code};
              done_d = 1'b1;
            end
            OP_CLEAR: begin
              col_d    = 7'd0;
              row_d    = 5'd0;
              sw_col_d = 7'd0;
              sw_row_d = 5'd0;
              state_d  = S_CLEAR;
            end
            OP_READ_CELL: begin
              raddr   = cell_addr(q_item_i.row, q_item_i.col);
              state_d = S_READ;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_READ: begin
        cchar_d  = rdata_q[7:0];
        cattr_d  = rdata_q[15:8];
        cvalid_d = 1'b1;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_TAB: begin
        we         = 1'b1;
        tab_left_d = tab_left_q - 5'd1;
        if (last_col) begin
          col_d = 7'd0;
          if (last_row) begin
            in_tab_d = ~last_space;
            sw_row_d = 5'd1;
            sw_col_d = 7'd0;
            pend_d   = 1'b0;
            state_d  = S_SCROLL;
          end else begin
            row_d = row_q + 5'd1;
            if (last_space) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end else begin
          col_d = col_q + 7'd1;
          if (last_space) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        // read row r while the cell read last cycle lands in row r-1
        raddr    = cell_addr(sw_row_q, sw_col_q);
        we       = pend_q;
        waddr    = wa_q;
        wdata    = rdata_q;
        pend_d   = 1'b1;
        wa_d     = cell_addr(sw_row_q - 5'd1, sw_col_q);
        sw_col_d = sw_col_q + 7'd1;
        if (sw_last_col) begin
          sw_col_d = 7'd0;
          sw_row_d = sw_row_q + 5'd1;
          if (sw_last_row) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        we       = 1'b1;
        waddr    = wa_q;
        wdata    = rdata_q;
        pend_d   = 1'b0;
        sw_row_d = 5'd0;
        state_d  = S_BLANK;
      end
      S_BLANK: begin
        we       = 1'b1;
        waddr    = cell_addr(ROW_LAST, sw_col_q);
        sw_col_d = sw_col_q + 7'd1;
        if (sw_last_col) begin
          sw_col_d = 7'd0;
          if (in_tab_q) begin
            in_tab_d = 1'b0;
            state_d  = S_TAB;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      col_q      <= 7'd0;
      row_q      <= 5'd0;
      sw_col_q   <= 7'd0;
      sw_row_q   <= 5'd0;
      pend_q     <= 1'b0;
      wa_q       <= '0;
      tab_left_q <= 5'd0;
      in_tab_q   <= 1'b0;
      done_q     <= 1'b0;
      cchar_q    <= 8'd0;
      cattr_q    <= 8'd0;
      cvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      sw_col_q   <= sw_col_d;
      sw_row_q   <= sw_row_d;
      pend_q     <= pend_d;
      wa_q       <= wa_d;
      tab_left_q <= tab_left_d;
      in_tab_q   <= in_tab_d;
      done_q     <= done_d;
      cchar_q    <= cchar_d;
      cattr_q    <= cattr_d;
      cvalid_q   <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/text_terminal_cursor_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Teletype engine for a COLUMNS x ROWS text screen with cursor and cell store.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with result_valid_o, in command
// order. The receiver cannot stall: results must be sampled when they appear.
// A two-item queue sits between the decoder and the executor, so start may
// be raised again while earlier commands are still running. After reset a
// clearing pass writes every cell with busy high. A tab writes one space per
// column up to the next tab stop; a scroll copies each row up by one and then
// blanks the last row; a clear blanks every cell. The screen store has a
// single write port. The attribute may be written only while idle.
module text_terminal_cursor_engine import tce_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [2:0]        command_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic signed [7:0] pos_x_i,
  input  wire logic signed [7:0] pos_y_i,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [7:0]        cfg_data_i,
  output      logic              result_valid_o,
  output      logic [6:0]        cursor_column_o,
  output      logic [4:0]        cursor_row_o,
  output      logic [10:0]       cursor_linear_o,
  output      logic [7:0]        cell_character_o,
  output      logic [7:0]        cell_attribute_o,
  output      logic              cell_valid_o
);

  logic [7:0] text_attr_q;
  logic       push, q_full, q_valid, pop, init;
  op_t        fe_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= RESET_ATTR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_attr_q <= cfg_data_i;
    end
  end

  tce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .q_full_i    (q_full),
    .init_i      (init),
    .push_o      (push),
    .item_o      (fe_item)
  );

  tce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fe_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .full_o  (q_full)
  );

  tce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .attr_i           (text_attr_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .pop_o            (pop),
    .init_o           (init),
    .done_o           (result_valid_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .cursor_linear_o  (cursor_linear_o),
    .cell_character_o (cell_character_o),
    .cell_attribute_o (cell_attribute_o),
    .cell_valid_o     (cell_valid_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tce_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks of the text terminal cursor engine, bound to the top.
// ----------------------------------------------------------------------------
module tce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        result_valid_o,
  input wire logic [6:0]  cursor_column_o,
  input wire logic [4:0]  cursor_row_o,
  input wire logic [10:0] cursor_linear_o,
  input wire logic [7:0]  cell_character_o,
  input wire logic [7:0]  cell_attribute_o,
  input wire logic        cell_valid_o
);

  localparam logic [6:0]  COLS_7  = 7'(COLUMNS);
  localparam logic [4:0]  ROWS_5  = 5'(ROWS - 1);
  localparam logic [10:0] COLS_11 = 11'(COLUMNS);

  a_cell_valid_with_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cell_valid_o |-> result_valid_o
  ) else $error("cell_valid without result strobe");

  a_miss_reads_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !cell_valid_o) |->
      (cell_character_o == 8'd0 && cell_attribute_o == 8'd0)
  ) else $error("cell bytes not zero without a cell hit");

  a_cursor_on_screen: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (cursor_column_o < COLS_7 && cursor_row_o <= ROWS_5)
  ) else $error("cursor off screen");

  a_linear_matches: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      cursor_linear_o == 11'({6'd0, cursor_row_o} * COLS_11) + {4'd0, cursor_column_o}
  ) else $error("cursor_linear does not match row and column");

endmodule

bind text_terminal_cursor_engine tce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tce_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .result_valid_o   (result_valid_o),
  .cursor_column_o  (cursor_column_o),
  .cursor_row_o     (cursor_row_o),
  .cursor_linear_o  (cursor_linear_o),
  .cell_character_o (cell_character_o),
  .cell_attribute_o (cell_attribute_o),
  .cell_valid_o     (cell_valid_o)
);
`default_nettype wire
